// ===== design/lis_pkg.sv =====
// Shared types, constants and helpers for the Lagrange interpolation sampler.
// No dependencies; every other design file imports this package.
package lis_pkg;

  localparam int DEF_MAX_POINTS  = 16;
  localparam int DEF_MAX_SAMPLES = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  // Command selector on the input channel
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_X     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_END_X       = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_X      = 2'd3;

  // Sample status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_CLIP = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // Register reset values
  localparam logic [4:0]  RST_POINT_COUNT = 5'd2;
  localparam logic [31:0] RST_START_X     = 32'd0;
  localparam logic [31:0] RST_END_X       = 32'd65536;
  localparam logic [30:0] RST_STEP_X      = 31'd65536;

  // Q16.16 one and signed 64-bit limits
  localparam logic [63:0] Q_ONE   = 64'd65536;
  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // One queued command from the front end
  typedef struct packed {
    logic        is_eval;
    logic [3:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
  } cmd_t;

  // Result of a multiply or divide: value and saturation flag
  typedef struct packed {
    logic [63:0] val;
    logic        sat;
  } qres_t;

  // Magnitude of a signed 64-bit value (minimum maps to 2^63)
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  // Apply sign to a magnitude and saturate to the signed 64-bit range
  function automatic qres_t from_mag(input logic over, input logic [63:0] m,
                                     input logic neg);
    qres_t r;
    r.sat = 1'b0;
    r.val = m;
    if (over) begin
      r.sat = 1'b1;
      r.val = neg ? S64_MIN : S64_MAX;
    end else if (neg) begin
      if (m > S64_MIN) begin
        r.sat = 1'b1;
        r.val = S64_MIN;
      end else begin
        r.val = 64'd0 - m;
      end
    end else if (m[63]) begin
      r.sat = 1'b1;
      r.val = S64_MAX;
    end
    return r;
  endfunction

endpackage

// ===== design/lis_front.sv =====
// Front end: accepts stream items, drops loads to missing slots, and queues
// commands for the engine. Depends on lis_pkg.
module lis_front #(
  parameter int MAX_POINTS = lis_pkg::DEF_MAX_POINTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lis_pkg::IN_TDATA_W-1:0]  in_tdata,  // point_index, node_x, node_y
  input  logic                            in_tuser,  // func
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output lis_pkg::cmd_t                   cmd
);
  import lis_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          q_mem [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;
  cmd_t          item;
  logic          keep, push, pop;

  // Classify the incoming item
  always_comb begin
    item.is_eval = (in_tuser == FUNC_EVAL);
    item.idx     = in_tdata[3:0];
    item.x       = in_tdata[35:4];
    item.y       = in_tdata[67:36];
    keep         = item.is_eval || ({28'd0, item.idx} < 32'(MAX_POINTS));
  end

  assign in_tready = (cnt_r != NW'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = cmd_valid && cmd_ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= item;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/lis_qmul.sv =====
// Q16.16 multiplier: 64x64 magnitude product from four 32x32 partial
// products, one per cycle, then shift and saturate. Depends on lis_pkg.
module lis_qmul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [63:0]    a,
  input  logic [63:0]    b,
  output logic           done,
  output lis_pkg::qres_t res
);
  import lis_pkg::*;

  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   psh_r;
  logic         pv_r, busy_r, done_r;
  logic [2:0]   step_r;
  qres_t        res_r;
  logic [31:0]  opa, opb;
  logic [127:0] pp_ext;
  qres_t        fin;

  // Pick the partial product operands and align the registered product
  always_comb begin
    opa = step_r[1] ? ma_r[63:32] : ma_r[31:0];
    opb = step_r[0] ? mb_r[63:32] : mb_r[31:0];
    case (psh_r)
      2'd0:    pp_ext = {64'd0, pp_r};
      2'd1:    pp_ext = {32'd0, pp_r, 32'd0};
      default: pp_ext = {pp_r, 64'd0};
    endcase
    fin = from_mag(|acc_r[127:80], acc_r[79:16], neg_r);
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        pv_r   <= (step_r < 3'd4);
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial products and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= mag64(a);
      mb_r  <= mag64(b);
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        pp_r  <= opa * opb;
        psh_r <= 2'({1'b0, step_r[1]} + {1'b0, step_r[0]});
      end
      if (pv_r) acc_r <= acc_r + pp_ext;
      if (step_r == 3'd5) res_r <= fin;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== design/lis_qdiv.sv =====
// Q16.16 divider: restoring division of |a|<<16 by |b|, one quotient bit
// per cycle, with saturation and a zero-divisor shortcut. Depends on lis_pkg.
module lis_qdiv (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [63:0]    a,
  input  logic [63:0]    b,
  output logic           done,
  output lis_pkg::qres_t res
);
  import lis_pkg::*;

  localparam int DIV_STEPS = 80;
  localparam int SW = $clog2(DIV_STEPS + 1);

  logic [63:0]   mb_r, rem_r;
  logic [79:0]   dvd_r;
  logic [SW-1:0] cnt_r;
  logic          neg_r, busy_r, done_r;
  qres_t         res_r;
  logic [64:0]   rem_w;
  logic          ge;
  logic [63:0]   rem_nxt;
  qres_t         zres;

  // One restoring step
  always_comb begin
    rem_w   = {rem_r, dvd_r[79]};
    ge      = (rem_w >= {1'b0, mb_r});
    rem_nxt = ge ? 64'(rem_w - {1'b0, mb_r}) : rem_w[63:0];
    zres.sat = 1'b1;
    if (a == 64'd0)  zres.val = 64'd0;
    else if (a[63])  zres.val = S64_MIN;
    else             zres.val = S64_MAX;
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= (b != 64'd0);
        done_r <= (b == 64'd0);
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SW'(DIV_STEPS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mb_r  <= mag64(b);
      dvd_r <= {mag64(a), 16'd0};
      rem_r <= '0;
      neg_r <= a[63] ^ b[63];
      if (b == 64'd0) res_r <= zres;
    end else if (busy_r) begin
      if (cnt_r == SW'(DIV_STEPS)) begin
        res_r <= from_mag(|dvd_r[79:63], dvd_r[63:0], neg_r);
      end else begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[78:0], ge};
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== design/lis_engine.sv =====
// Back end: point tables, denominator pass, per-sample evaluation sequencer
// and output register. Depends on lis_pkg, lis_qmul and lis_qdiv.
module lis_engine #(
  parameter int MAX_POINTS  = lis_pkg::DEF_MAX_POINTS,
  parameter int MAX_SAMPLES = lis_pkg::DEF_MAX_SAMPLES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  lis_pkg::cmd_t                   cmd,
  input  logic                            cfg_we,
  input  logic [lis_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lis_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lis_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic [1:0]                      out_tuser
);
  import lis_pkg::*;

  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [39:0] MAXS_W = 40'(MAX_SAMPLES);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DJ_RD   = 5'd1;
  localparam logic [4:0] S_DJ_LAT  = 5'd2;
  localparam logic [4:0] S_DI_CHK  = 5'd3;
  localparam logic [4:0] S_DI_MUL  = 5'd4;
  localparam logic [4:0] S_DI_WAIT = 5'd5;
  localparam logic [4:0] S_SETUP   = 5'd6;
  localparam logic [4:0] S_SMP     = 5'd7;
  localparam logic [4:0] S_PJ      = 5'd8;
  localparam logic [4:0] S_PI_CHK  = 5'd9;
  localparam logic [4:0] S_PI_MUL  = 5'd10;
  localparam logic [4:0] S_PI_WAIT = 5'd11;
  localparam logic [4:0] S_Q_DIV   = 5'd12;
  localparam logic [4:0] S_Q_WAIT  = 5'd13;
  localparam logic [4:0] S_T_MUL   = 5'd14;
  localparam logic [4:0] S_T_WAIT  = 5'd15;
  localparam logic [4:0] S_EMIT    = 5'd16;

  // Configuration registers
  logic [4:0]  pc_r;
  logic [31:0] start_r, end_r;
  logic [30:0] step_r;

  // Tables
  logic [31:0] tx_mem  [MAX_POINTS];
  logic [31:0] ty_mem  [MAX_POINTS];
  logic [63:0] den_mem [MAX_POINTS];
  logic [31:0] x_rd_r, y_rd_r;
  logic [63:0] den_rd_r;

  // Sequencer state
  logic [4:0]         state_r, state_nxt;
  logic [CW-1:0]      i_r, i_nxt, j_r, j_nxt, n_r, n_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [31:0]        xj_r, xj_nxt;
  logic [63:0]        d_r, d_nxt, p_r, p_nxt, q_r, q_nxt, sum_r, sum_nxt;
  logic               sat_r, sat_nxt, dsat_r, dsat_nxt, dup_r, dup_nxt;
  logic               clip_r, clip_nxt;
  logic signed [39:0] diff_r, diff_nxt, x_r, x_nxt, off_r, off_nxt;

  // Output register
  logic                   out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] out_d_r;
  logic                   out_l_r;
  logic [1:0]             out_u_r;
  logic                   out_load;
  logic                   emit_last;
  logic [31:0]            y32;
  logic [1:0]             st_code;

  // Unit handshakes
  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, div_a, div_b;
  qres_t       mul_res, div_res;

  logic          load_we, den_we;
  logic [PW-1:0] rd_idx;
  logic [PW-1:0] widx;

  // Setup and emit helpers
  logic [32:0]        diff33, ndiff;
  logic [39:0]        stmax, step40, off_step;
  logic               cnt_zero, clip_now, in_rng;
  logic [63:0]        add_s;
  logic               add_ovf;
  logic [63:0]        add_v;

  assign rd_idx = (state_r == S_DJ_RD) ? j_r[PW-1:0] : i_r[PW-1:0];
  assign widx   = PW'(cmd.idx);

  lis_qmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  lis_qdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .res   (div_res)
  );

  // Table storage, read registered
  always_ff @(posedge clk) begin
    if (load_we) begin
      tx_mem[widx] <= cmd.x;
      ty_mem[widx] <= cmd.y;
    end
    x_rd_r <= tx_mem[rd_idx];
    y_rd_r <= ty_mem[j_r[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (den_we) den_mem[j_r[PW-1:0]] <= d_r;
    den_rd_r <= den_mem[j_r[PW-1:0]];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= RST_POINT_COUNT;
      start_r <= RST_START_X;
      end_r   <= RST_END_X;
      step_r  <= RST_STEP_X;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POINT_COUNT: pc_r    <= cfg_wdata[4:0];
        CFG_START_X:     start_r <= cfg_wdata;
        CFG_END_X:       end_r   <= cfg_wdata;
        CFG_STEP_X:      step_r  <= cfg_wdata[30:0];
        default:         ;
      endcase
    end
  end

  // Unit operand selection
  always_comb begin
    mul_a = d_r;
    mul_b = {{32{xj_r[31]}}, xj_r} - {{32{x_rd_r[31]}}, x_rd_r};
    unique case (state_r)
      S_PI_MUL: begin
        mul_a = p_r;
        mul_b = {{24{x_r[39]}}, x_r} - {{32{x_rd_r[31]}}, x_rd_r};
      end
      S_T_MUL: begin
        mul_a = q_r;
        mul_b = {{32{y_rd_r[31]}}, y_rd_r};
      end
      default: ;
    endcase
    div_a = p_r;
    div_b = den_rd_r;
  end

  // Run length, clipping and sample result shaping
  always_comb begin
    diff33   = {end_r[31], end_r} - {start_r[31], start_r};
    ndiff    = 33'd0 - diff33;
    step40   = {9'd0, step_r};
    stmax    = step40 * MAXS_W;
    clip_now = (step_r == '0) ||
               (!diff33[32] && (stmax <= {7'd0, diff33}));
    cnt_zero = (step_r != '0) && diff33[32] && ({2'd0, step_r} <= ndiff);

    off_step  = 40'(off_r) + step40;
    emit_last = (k_r == KW'(MAX_SAMPLES - 1)) ||
                ((step_r != '0) && ($signed(off_step) > diff_r));

    in_rng = (sum_r[63:31] == {33{sum_r[31]}});
    if (dup_r)        y32 = 32'd0;
    else if (in_rng)  y32 = sum_r[31:0];
    else if (sum_r[63]) y32 = 32'h8000_0000;
    else              y32 = 32'h7FFF_FFFF;
    if (dup_r)                 st_code = ST_DUP;
    else if (sat_r || !in_rng) st_code = ST_SAT;
    else if (clip_r)           st_code = ST_CLIP;
    else                       st_code = ST_OK;

    add_s   = sum_r + mul_res.val;
    add_ovf = (sum_r[63] == mul_res.val[63]) && (add_s[63] != sum_r[63]);
    add_v   = add_ovf ? (mul_res.val[63] ? S64_MIN : S64_MAX) : add_s;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    xj_nxt    = xj_r;
    d_nxt     = d_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    sum_nxt   = sum_r;
    sat_nxt   = sat_r;
    dsat_nxt  = dsat_r;
    dup_nxt   = dup_r;
    clip_nxt  = clip_r;
    diff_nxt  = diff_r;
    x_nxt     = x_r;
    off_nxt   = off_r;
    cmd_ready = 1'b0;
    load_we   = 1'b0;
    den_we    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (!cmd.is_eval) begin
            load_we = 1'b1;
          end else begin
            n_nxt    = ({27'd0, pc_r} > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pc_r);
            j_nxt    = '0;
            dup_nxt  = 1'b0;
            dsat_nxt = 1'b0;
            state_nxt = (n_nxt == '0) ? S_SETUP : S_DJ_RD;
          end
        end
      end
      S_DJ_RD: state_nxt = S_DJ_LAT;
      S_DJ_LAT: begin
        xj_nxt    = x_rd_r;
        d_nxt     = Q_ONE;
        i_nxt     = '0;
        state_nxt = S_DI_CHK;
      end
      S_DI_CHK: begin
        if (i_r == n_r) begin
          den_we    = 1'b1;
          j_nxt     = j_r + 1'b1;
          state_nxt = (j_nxt == n_r) ? S_SETUP : S_DJ_RD;
        end else if (i_r == j_r) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = S_DI_MUL;
        end
      end
      S_DI_MUL: begin
        if (xj_r == x_rd_r) dup_nxt = 1'b1;
        mul_start = 1'b1;
        state_nxt = S_DI_WAIT;
      end
      S_DI_WAIT: begin
        if (mul_done) begin
          d_nxt     = mul_res.val;
          dsat_nxt  = dsat_r | mul_res.sat;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_DI_CHK;
        end
      end
      S_SETUP: begin
        clip_nxt  = clip_now;
        diff_nxt  = {{7{diff33[32]}}, diff33};
        x_nxt     = {{8{start_r[31]}}, start_r};
        off_nxt   = '0;
        k_nxt     = '0;
        state_nxt = cnt_zero ? S_IDLE : S_SMP;
      end
      S_SMP: begin
        sum_nxt = '0;
        sat_nxt = dsat_r;
        j_nxt   = '0;
        if (dup_r || (n_r == '0)) state_nxt = S_EMIT;
        else                      state_nxt = S_PJ;
      end
      S_PJ: begin
        p_nxt     = Q_ONE;
        i_nxt     = '0;
        state_nxt = S_PI_CHK;
      end
      S_PI_CHK: begin
        if (i_r == n_r)       state_nxt = S_Q_DIV;
        else if (i_r == j_r)  i_nxt = i_r + 1'b1;
        else                  state_nxt = S_PI_MUL;
      end
      S_PI_MUL: begin
        mul_start = 1'b1;
        state_nxt = S_PI_WAIT;
      end
      S_PI_WAIT: begin
        if (mul_done) begin
          p_nxt     = mul_res.val;
          sat_nxt   = sat_r | mul_res.sat;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PI_CHK;
        end
      end
      S_Q_DIV: begin
        div_start = 1'b1;
        state_nxt = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (div_done) begin
          q_nxt     = div_res.val;
          sat_nxt   = sat_r | div_res.sat;
          state_nxt = S_T_MUL;
        end
      end
      S_T_MUL: begin
        mul_start = 1'b1;
        state_nxt = S_T_WAIT;
      end
      S_T_WAIT: begin
        if (mul_done) begin
          sum_nxt   = add_v;
          sat_nxt   = sat_r | mul_res.sat | add_ovf;
          j_nxt     = j_r + 1'b1;
          state_nxt = (j_nxt == n_r) ? S_EMIT : S_PJ;
        end
      end
      S_EMIT: begin
        if (!out_v_r || out_tready) begin
          out_load = 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            x_nxt     = x_r + $signed(step40);
            off_nxt   = $signed(off_step);
            state_nxt = S_SMP;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load)        out_v_nxt = 1'b1;
    else if (out_tready) out_v_nxt = 1'b0;
    else                 out_v_nxt = out_v_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload and loop registers
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    xj_r   <= xj_nxt;
    d_r    <= d_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    sum_r  <= sum_nxt;
    sat_r  <= sat_nxt;
    dsat_r <= dsat_nxt;
    dup_r  <= dup_nxt;
    clip_r <= clip_nxt;
    diff_r <= diff_nxt;
    x_r    <= x_nxt;
    off_r  <= off_nxt;
    if (out_load) begin
      out_d_r <= {y32, x_r[31:0]};
      out_l_r <= emit_last;
      out_u_r <= st_code;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_u_r;

endmodule

// ===== design/lagrange_interpolation_sampler_top.sv =====
// Top level of the Lagrange interpolation sampler: front-end queue plus
// evaluation engine. Depends on lis_pkg, lis_front and lis_engine.
//
//   channel | dir | transfer on            | payload
//   in_     | in  | in_tvalid & in_tready  | tuser func; tdata index, x, y
//   out_    | out | out_tvalid & out_tready| tdata x, y; tlast; tuser status
//   cfg_    | in  | cfg_we                 | cfg_addr register, cfg_wdata
//
// A load item is written to the tables from the idle state. An evaluate
// item with n points first forms the n denominators with the four-pass
// multiplier, then evaluates each sample with the multiplier and the
// 80-step divider, which one sequencer shares. Reset is synchronous, active
// low, and restores the register defaults; tables hold no reset state. A
// stalled output holds the engine in place while the front queue keeps
// taking items until full.
module lagrange_interpolation_sampler_top #(
  parameter int MAX_POINTS  = lis_pkg::DEF_MAX_POINTS,
  parameter int MAX_SAMPLES = lis_pkg::DEF_MAX_SAMPLES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lis_pkg::IN_TDATA_W-1:0]  in_tdata,   // point_index[3:0], node_x[35:4],
                                                      // node_y[67:36], zero pad
  input  logic                            in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lis_pkg::OUT_TDATA_W-1:0] out_tdata,  // sample_x[31:0], sample_y[63:32]
  output logic                            out_tlast,
  output logic [1:0]                      out_tuser,  // status
  input  logic                            cfg_we,
  input  logic [lis_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lis_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lis_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  lis_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  lis_engine #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/sv/tb_lagrange_interpolation_sampler_top.sv =====
// Self-checking testbench for the Lagrange interpolation sampler top level.
// A directed table followed by random load/evaluate rounds, checked against
// an in-bench fixed-point predictor. Depends on lis_pkg and the design.
`timescale 1ns / 1ps

module tb_lagrange_interpolation_sampler_top;
  import lis_pkg::*;

  localparam int NODES      = 16;
  localparam int SAMPLE_CAP = 64;
  localparam int SETTLE     = 8000;
  localparam int STALL_LIM  = 30000;
  localparam int RAND_ITEMS = 300;

  typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           wdata;
    logic [3:0]            idx;
    logic [31:0]           x;
    logic [31:0]           y;
    bit                    typed;
    logic [31:0]           ty;
    logic [1:0]            tst;
  } row_t;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        lst;
    logic [1:0]  st;
  } sample_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = FUNC_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [1:0]             out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = CFG_POINT_COUNT;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Predictor state: register shadows and node tables
  logic [4:0]  cur_count;
  logic [31:0] cur_start;
  logic [31:0] cur_end;
  logic [30:0] cur_step;
  longint      tab_x [NODES];
  longint      tab_y [NODES];
  longint      node_den [NODES];
  bit   [15:0] loaded_slots;

  sample_t     samples_due [$];
  bit          typed_on;
  logic [31:0] typed_y;
  logic [1:0]  typed_st;

  int  errors;
  int  mismatches;
  int  burst_left;
  int  items_sent;
  int  stall_cycles;
  bit  hold_req;
  bit  pressure_done;

  lagrange_interpolation_sampler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- fixed-point arithmetic ----------------

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // Apply sign to a magnitude, clamp to the signed 64-bit range
  function automatic longint apply_sign(input logic [63:0] m, input bit neg,
                                        inout bit sat);
    if (neg) begin
      if (m > S64_MIN) begin
        sat = 1'b1;
        return longint'(S64_MIN);
      end
      return longint'(64'd0 - m);
    end
    if (m[63]) begin
      sat = 1'b1;
      return longint'(S64_MAX);
    end
    return longint'(m);
  endfunction

  function automatic longint q_mul(input longint a, input longint b, inout bit sat);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    m = (p[127:80] != 0) ? '1 : p[79:16];
    return apply_sign(m, (a < 0) != (b < 0), sat);
  endfunction

  function automatic longint q_div(input longint a, input longint b, inout bit sat);
    logic [127:0] q;
    logic [63:0]  m;
    if (b == 0) begin
      sat = 1'b1;
      if (a == 0) return 0;
      return a > 0 ? longint'(S64_MAX) : longint'(S64_MIN);
    end
    q = ({64'd0, magnitude(a)} << 16) / {64'd0, magnitude(b)};
    m = (q[127:63] != 0) ? '1 : q[63:0];
    return apply_sign(m, (a < 0) != (b < 0), sat);
  endfunction

  function automatic longint sat_add(input longint a, input longint b, inout bit sat);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat = 1'b1;
      return s[64] ? longint'(S64_MIN) : longint'(S64_MAX);
    end
    return longint'(s[63:0]);
  endfunction

  // ---------------- predictor ----------------

  task automatic predictor_reset();
    cur_count = RST_POINT_COUNT;
    cur_start = RST_START_X;
    cur_end   = RST_END_X;
    cur_step  = RST_STEP_X;
    loaded_slots = '0;
    for (int i = 0; i < NODES; i++) begin
      tab_x[i] = 0;
      tab_y[i] = 0;
      node_den[i] = 0;
    end
  endtask

  task automatic predictor_cfg(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
    case (a)
      CFG_POINT_COUNT: cur_count = d[4:0];
      CFG_START_X:     cur_start = d;
      CFG_END_X:       cur_end   = d;
      CFG_STEP_X:      cur_step  = d[30:0];
      default: ;
    endcase
  endtask

  // Form denominators, then queue every sample the evaluate will emit
  task automatic predict_samples();
    int      n;
    int      cnt;
    bit      dup;
    bit      den_sat;
    bit      clipped;
    bit      sat;
    longint  s;
    longint  e;
    longint  st;
    longint  r;
    longint  x;
    longint  p;
    longint  sum;
    sample_t smp;
    n = (cur_count > NODES) ? NODES : int'(cur_count);
    dup = 1'b0;
    den_sat = 1'b0;
    clipped = 1'b0;
    for (int j = 0; j < n; j++) begin
      node_den[j] = longint'(Q_ONE);
      for (int i = 0; i < n; i++) begin
        if (i == j) continue;
        if (tab_x[i] == tab_x[j]) dup = 1'b1;
        node_den[j] = q_mul(node_den[j], tab_x[j] - tab_x[i], den_sat);
      end
    end
    s  = longint'(signed'(cur_start));
    e  = longint'(signed'(cur_end));
    st = longint'(cur_step);
    if (st == 0) begin
      cnt = SAMPLE_CAP;
      clipped = 1'b1;
    end else begin
      r = (e - s) / st;
      if (r < 0) cnt = 0;
      else if (r >= SAMPLE_CAP) begin
        cnt = SAMPLE_CAP;
        clipped = 1'b1;
      end else cnt = int'(r) + 1;
    end
    for (int k = 0; k < cnt; k++) begin
      x = s + longint'(k) * st;
      smp.sx  = x[31:0];
      smp.lst = (k == cnt - 1);
      if (dup) begin
        smp.sy = '0;
        smp.st = ST_DUP;
      end else begin
        sat = den_sat;
        sum = 0;
        for (int j = 0; j < n; j++) begin
          p = longint'(Q_ONE);
          for (int i = 0; i < n; i++)
            if (i != j) p = q_mul(p, x - tab_x[i], sat);
          p = q_div(p, node_den[j], sat);
          p = q_mul(p, tab_y[j], sat);
          sum = sat_add(sum, p, sat);
        end
        if (sum > 64'sd2147483647) begin
          sum = 64'sd2147483647;
          sat = 1'b1;
        end
        if (sum < -64'sd2147483648) begin
          sum = -64'sd2147483648;
          sat = 1'b1;
        end
        smp.sy = sum[31:0];
        smp.st = sat ? ST_SAT : (clipped ? ST_CLIP : ST_OK);
      end
      if (typed_on) begin
        smp.sy = typed_y;
        smp.st = typed_st;
      end
      samples_due.push_back(smp);
    end
  endtask

  // ---------------- drivers ----------------

  // Offer one item in bursts; predict it on transfer
  task automatic send_item(input logic func, input logic [3:0] idx,
                           input logic [31:0] x, input logic [31:0] y);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {4'd0, y, x, idx};
    do @(posedge clk); while (!in_tready);
    if (func == FUNC_LOAD) begin
      tab_x[idx] = longint'(signed'(x));
      tab_y[idx] = longint'(signed'(y));
      loaded_slots[idx] = 1'b1;
    end else begin
      predict_samples();
    end
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Wait for all results, then let an evaluate without results finish
  task automatic drain();
    in_tvalid = 1'b0;
    while (samples_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
    cfg_we    = 1'b1;
    cfg_addr  = a;
    cfg_wdata = d;
    predictor_cfg(a, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: ready pattern changes at random; long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (2000) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = $urandom_range(0, 1);
        default: out_tready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result check against the oldest queued sample
  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (samples_due.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected sample x=%h y=%h last=%b st=%0d", out_tdata[31:0],
                   out_tdata[63:32], out_tlast, out_tuser);
      end else begin
        e = samples_due.pop_front();
        if (out_tdata[31:0] !== e.sx || out_tdata[63:32] !== e.sy ||
            out_tlast !== e.lst || out_tuser !== e.st) begin
          errors++;
          if (mismatches++ < 10)
            $display("sample mismatch: exp x=%h y=%h last=%b st=%0d, got x=%h y=%h last=%b st=%0d",
                     e.sx, e.sy, e.lst, e.st, out_tdata[31:0], out_tdata[63:32],
                     out_tlast, out_tuser);
        end
      end
    end
  end

  // Watchdog: cycles with work pending and no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (samples_due.size() == 0 && !in_tvalid))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIM) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  row_t plan [] = '{
    '{ROW_LOAD, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_LOAD, CFG_POINT_COUNT, 0, 4'd1, 32'h0001_0000, 32'h0001_0000, 0, 0, ST_OK},
    '{ROW_EVAL, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    // both used nodes at x=0
    '{ROW_LOAD, CFG_POINT_COUNT, 0, 4'd1, 32'h0, 32'h7fff_ffff, 0, 0, ST_OK},
    '{ROW_EVAL, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 1, 32'h0, ST_DUP},
    // no nodes: empty sum
    '{ROW_CFG,  CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_EVAL, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 1, 32'h0, ST_OK},
    // extreme nodes and full-span sampling
    '{ROW_CFG,  CFG_POINT_COUNT, 3, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_LOAD, CFG_POINT_COUNT, 0, 4'd1, 32'h8000_0000, 32'h7fff_ffff, 0, 0, ST_OK},
    '{ROW_LOAD, CFG_POINT_COUNT, 0, 4'd2, 32'h7fff_ffff, 32'h8000_0000, 0, 0, ST_OK},
    '{ROW_LOAD, CFG_POINT_COUNT, 0, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 0, 0, ST_OK},
    '{ROW_CFG,  CFG_START_X, 32'h8000_0000, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_CFG,  CFG_END_X,   32'h7fff_ffff, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_CFG,  CFG_STEP_X,  32'h7fff_ffff, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_EVAL, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    // zero step: clipped run at start
    '{ROW_CFG,  CFG_STEP_X,  32'h0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_EVAL, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    // end before start: no samples, then exactly one
    '{ROW_CFG,  CFG_STEP_X,  32'h0001_0000, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_CFG,  CFG_START_X, 32'h0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_CFG,  CFG_END_X,   32'hffff_0000, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_EVAL, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_CFG,  CFG_END_X,   32'h0000_ffff, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK},
    '{ROW_EVAL, CFG_POINT_COUNT, 0, 4'd0, 32'h0, 32'h0, 0, 0, ST_OK}
  };

  // One random round: registers, node loads, evaluate, trailing noise loads
  task automatic random_round();
    int          pick;
    int          n;
    int          nsamp;
    int          gap;
    logic [31:0] base;
    logic [31:0] start_v;
    logic [31:0] step_v;
    logic [31:0] end_v;
    logic [31:0] xv;
    logic [31:0] yv;
    bit          wide_vals;
    pick = $urandom_range(0, 99);
    if (pick < 70) n = $urandom_range(1, 4);
    else if (pick < 88) n = $urandom_range(5, 8);
    else if (pick < 92) n = 0;
    else if (pick < 96) n = 16;
    else n = $urandom_range(17, 31);
    // sample span; wide spans only with few nodes
    pick = $urandom_range(0, 99);
    start_v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    step_v  = $urandom_range(32'h1000, 32'h2_0000);
    nsamp   = $urandom_range(1, 8);
    if (n >= 9 || n == 0) nsamp = 1;
    end_v = start_v + (nsamp - 1) * step_v + $urandom_range(0, step_v - 1);
    if (n <= 3 && n > 0) begin
      if (pick < 15) begin
        start_v = $urandom();
        step_v  = $urandom() & 32'h7fff_ffff;
        end_v   = $urandom();
      end else if (pick < 22) begin
        step_v = $urandom_range(1, 32'h800);
        end_v  = start_v + step_v * $urandom_range(64, 200);
      end else if (pick < 26) begin
        step_v = 0;
      end
    end
    if (pick >= 90) end_v = start_v - step_v * $urandom_range(1, 4);
    write_reg(CFG_POINT_COUNT, n);
    write_reg(CFG_START_X, start_v);
    write_reg(CFG_END_X, end_v);
    write_reg(CFG_STEP_X, step_v);
    // nodes: mostly spread and distinct, sometimes full range or repeated
    n = (n > NODES) ? NODES : n;
    wide_vals = ($urandom_range(0, 9) == 0);
    base = start_v - $urandom_range(0, 32'h4_0000);
    gap  = $urandom_range(32'h2000, 32'h2_0000);
    for (int j = 0; j < n; j++) begin
      if (loaded_slots[j] && $urandom_range(0, 4) == 0) continue;
      xv = wide_vals ? $urandom() : base + j * gap + $urandom_range(0, 255);
      yv = wide_vals ? $urandom() : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      if (j > 0 && $urandom_range(0, 19) == 0) xv = tab_x[j-1][31:0];
      send_item(FUNC_LOAD, j, xv, yv);
    end
    if (n > 0 && $urandom_range(0, 3) == 0)
      send_item(FUNC_LOAD, $urandom_range(n - 1, 15), $urandom(), $urandom());
    // one long receiver hold-off against a clipped run
    if (!pressure_done && step_v != 0 && n > 0 && n <= 3 &&
        ((end_v - start_v) / step_v) >= 64 && !end_v[31] && !start_v[31]) begin
      hold_req = 1'b1;
      pressure_done = 1'b1;
    end
    send_item(FUNC_EVAL, $urandom(), $urandom(), $urandom());
    repeat ($urandom_range(0, 3))
      send_item(FUNC_LOAD, $urandom_range(n, 15) & 4'hf, $urandom(), $urandom());
    if ($urandom_range(0, 5) == 0)
      send_item(FUNC_EVAL, $urandom(), $urandom(), $urandom());
  endtask

  initial begin
    errors = 0;
    mismatches = 0;
    burst_left = 0;
    items_sent = 0;
    stall_cycles = 0;
    hold_req = 1'b0;
    pressure_done = 1'b0;
    typed_on = 1'b0;
    predictor_reset();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(plan[i].addr, plan[i].wdata);
        end
        ROW_LOAD: send_item(FUNC_LOAD, plan[i].idx, plan[i].x, plan[i].y);
        default: begin
          typed_on = plan[i].typed;
          typed_y  = plan[i].ty;
          typed_st = plan[i].tst;
          send_item(FUNC_EVAL, plan[i].idx, plan[i].x, plan[i].y);
          typed_on = 1'b0;
        end
      endcase
    end

    // Hold the receiver off during a long clipped run while loads keep coming
    drain();
    write_reg(CFG_POINT_COUNT, 32'd2);
    write_reg(CFG_START_X, 32'h0);
    write_reg(CFG_END_X, 32'h0001_0000);
    write_reg(CFG_STEP_X, 32'h0000_0100);
    send_item(FUNC_LOAD, 4'd0, 32'h0, 32'h0001_0000);
    send_item(FUNC_LOAD, 4'd1, 32'h0001_0000, 32'h0003_0000);
    hold_req = 1'b1;
    pressure_done = 1'b1;
    send_item(FUNC_EVAL, 4'd0, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++)
      send_item(FUNC_LOAD, 4'd5, 32'(i) << 16, 32'h0);

    // Random rounds, each started from an idle block
    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      drain();
      random_round();
    end

    drain();
    if (errors == 0 && samples_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
